[sv/mwst_pkg.sv]
// ----------------------------------------------------------------------------
// mwst_pkg
// shared constants for the maximum window sum tracker: field widths and
// default sizing of the sample ring
// ----------------------------------------------------------------------------
package mwst_pkg;

   // default sizing
   localparam int DEF_MAX_WINDOW  = 1024;
   localparam int DEF_SAMPLE_BITS = 32;

   // fixed field widths of the channels
   localparam int SAMPLE_FIELD_W = 32;
   localparam int LEN_CFG_W      = 11;
   localparam int MAX_SUM_W      = 42;
   localparam int RSP_TDATA_W    = 48;

   // window length after reset
   localparam int LEN_RESET = 1;

endpackage

[sv/mwst_ram.sv]
// ----------------------------------------------------------------------------
// mwst_ram
// generic simple dual port ram, one write and one registered read port,
// read returns the old contents when both ports hit the same entry
// ----------------------------------------------------------------------------
module mwst_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[sv/max_window_sum_tracker.sv]
// ----------------------------------------------------------------------------
// max_window_sum_tracker
// maximum sum over a fixed size sliding window of a signed sample stream
// ----------------------------------------------------------------------------
// usage:
//   req_* carries one sample per item, req_tlast marks the last sample of a
//   sequence. rsp_* gives one item per sequence, on its last sample: the
//   best full-window sum (0 if none) and a flag in rsp_tuser telling whether
//   any full window occurred. csr_wen/csr_wdata set the window length; a
//   length of 0 acts as 1, a length above MAX_WINDOW acts as MAX_WINDOW,
//   and every write also starts a fresh sequence. write it only while idle.
//   throughput: one item per cycle while not stalled. the result reaches
//   rsp_tdata through the ring read, difference, running sum and best
//   compare into the output reg.
//   the past samples live in a MAX_WINDOW deep ring memory with one write
//   and one read port: each item writes its sample and reads the one that
//   leaves the window in the same cycle.
//   reset clears the control state and sets the window length to 1; the
//   ring needs no clearing since only entries of the current sequence are
//   read back. a stalled receiver holds the result; samples keep flowing
//   until another result would have to enter the occupied output register.
// ----------------------------------------------------------------------------
module max_window_sum_tracker
   import mwst_pkg::*;
#(
   parameter int MAX_WINDOW  = DEF_MAX_WINDOW,
   parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
   input  logic                      clock,
   input  logic                      reset,
   // input items
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [SAMPLE_FIELD_W-1:0] req_tdata,   // [31:0] sample
   input  logic                      req_tlast,   // last_sample
   // result items
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [RSP_TDATA_W-1:0]    rsp_tdata,   // [41:0] max_sum, rest zero
   output logic                      rsp_tuser,   // [0] window_seen
   // window length register
   input  logic                      csr_wen,
   input  logic [LEN_CFG_W-1:0]      csr_wdata    // [10:0] window_len
);

   localparam int ADDR_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
   localparam int LEN_W  = $clog2(MAX_WINDOW + 1);
   localparam int PTR_W  = LEN_W + 1;
   localparam int EXT_W  = (SAMPLE_BITS > SAMPLE_FIELD_W) ? SAMPLE_BITS : SAMPLE_FIELD_W;
   localparam int DIFF_W = SAMPLE_BITS + 1;
   localparam int SUM_W  = SAMPLE_BITS + $clog2(MAX_WINDOW) + 1;
   localparam int OUT_W  = (SUM_W > MAX_SUM_W) ? SUM_W : MAX_SUM_W;

   // ------------------------------------------------------------------
   // window length register, stored already saturated
   // ------------------------------------------------------------------
   logic [LEN_W-1:0] len_ff, len_in;
   logic [31:0]      csr_wide;

   assign csr_wide = 32'(csr_wdata);

   always_comb begin
      priority if (csr_wide == 32'd0) begin
         len_in = LEN_W'(1);
      end else if (csr_wide > 32'(MAX_WINDOW)) begin
         len_in = LEN_W'(MAX_WINDOW);
      end else begin
         len_in = csr_wide[LEN_W-1:0];
      end
   end

   // ------------------------------------------------------------------
   // pipeline control: stall only when a result meets a full output reg
   // ------------------------------------------------------------------
   logic advance;
   logic accept;
   logic v3_ff, last3_ff;
   logic rsp_valid_ff;

   assign advance    = !(v3_ff && last3_ff && rsp_valid_ff && !rsp_tready);
   assign req_tready = advance;
   assign accept     = req_tvalid && advance;

   // ------------------------------------------------------------------
   // stage 0: ring access, write pointer and fill count
   // ------------------------------------------------------------------
   logic [ADDR_W-1:0]      wp_ff, wp_in;
   logic [LEN_W-1:0]       fill_ff, fill_in;
   logic [LEN_W-1:0]       fill_next;
   logic [PTR_W-1:0]       old_diff;
   logic [PTR_W-1:0]       old_wrap;
   logic [ADDR_W-1:0]      old_addr;
   logic [EXT_W-1:0]       samp_ext;
   logic [SAMPLE_BITS-1:0] samp;
   logic                   s0_sub;
   logic                   s0_full;
   logic                   s0_first;

   assign samp_ext = EXT_W'(req_tdata);
   assign samp     = samp_ext[SAMPLE_BITS-1:0];

   // oldest sample slot: write pointer minus window length, modulo depth
   assign old_diff = PTR_W'(wp_ff) - PTR_W'(len_ff);
   assign old_wrap = old_diff + PTR_W'(MAX_WINDOW);
   assign old_addr = old_diff[PTR_W-1] ? old_wrap[ADDR_W-1:0] : old_diff[ADDR_W-1:0];

   assign s0_sub    = (fill_ff >= len_ff);
   assign fill_next = s0_sub ? fill_ff : fill_ff + LEN_W'(1);
   assign s0_full   = (fill_next >= len_ff);
   assign s0_first  = (fill_ff == '0);

   always_comb begin
      wp_in   = wp_ff;
      fill_in = fill_ff;
      priority if (csr_wen) begin
         wp_in   = '0;
         fill_in = '0;
      end else if (accept && req_tlast) begin
         // sequence ends: start over
         wp_in   = '0;
         fill_in = '0;
      end else if (accept) begin
         wp_in   = (wp_ff == ADDR_W'(MAX_WINDOW - 1)) ? '0 : wp_ff + ADDR_W'(1);
         fill_in = fill_next;
      end else begin
         wp_in   = wp_ff;
         fill_in = fill_ff;
      end
   end

   logic [SAMPLE_BITS-1:0] ring_rd_data;

   mwst_ram #(
      .WIDTH (SAMPLE_BITS),
      .DEPTH (MAX_WINDOW),
      .ADDR_W(ADDR_W)
   ) u_ring (
      .clock  (clock),
      .wr_en  (accept),
      .wr_addr(wp_ff),
      .wr_data(samp),
      .rd_en  (advance),
      .rd_addr(old_addr),
      .rd_data(ring_rd_data)
   );

   // ------------------------------------------------------------------
   // stage 1: new sample minus leaving sample
   // ------------------------------------------------------------------
   logic                          v1_ff, last1_ff, sub1_ff, full1_ff, first1_ff;
   logic signed [SAMPLE_BITS-1:0] samp1_ff;
   logic signed [SAMPLE_BITS-1:0] old_s;
   logic signed [DIFF_W-1:0]      diff1;

   assign old_s = sub1_ff ? signed'(ring_rd_data) : '0;
   assign diff1 = DIFF_W'(samp1_ff) - DIFF_W'(old_s);

   // ------------------------------------------------------------------
   // stage 2: running window sum
   // ------------------------------------------------------------------
   logic                     v2_ff, last2_ff, full2_ff, first2_ff;
   logic signed [DIFF_W-1:0] diff2_ff;
   logic signed [SUM_W-1:0]  ws_ff, ws_in;
   logic signed [SUM_W-1:0]  ws_base;

   assign ws_base = first2_ff ? '0 : ws_ff;
   assign ws_in   = ws_base + SUM_W'(diff2_ff);

   // ------------------------------------------------------------------
   // stage 3: best sum tracking and result
   // ------------------------------------------------------------------
   logic                    full3_ff, first3_ff;
   logic signed [SUM_W-1:0] best_ff, best_in;
   logic                    bv_ff, bv_in;
   logic                    bv_eff;
   logic                    take_new;
   logic signed [OUT_W-1:0] best_wide;
   logic [MAX_SUM_W-1:0]    rsp_sum_ff, rsp_sum_in;
   logic                    rsp_seen_ff;

   assign bv_eff   = bv_ff && !first3_ff;
   assign take_new = full3_ff && (!bv_eff || (ws_ff > best_ff));
   assign best_in  = take_new ? ws_ff : best_ff;
   assign bv_in    = bv_eff || full3_ff;
   assign best_wide  = OUT_W'(best_in);
   assign rsp_sum_in = bv_in ? best_wide[MAX_SUM_W-1:0] : '0;

   // ------------------------------------------------------------------
   // registers
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff       <= LEN_W'(LEN_RESET);
         wp_ff        <= '0;
         fill_ff      <= '0;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wen) begin
            len_ff <= len_in;
         end
         wp_ff   <= wp_in;
         fill_ff <= fill_in;
         if (advance) begin
            v1_ff <= accept;
            v2_ff <= v1_ff;
            v3_ff <= v2_ff;
         end
         priority if (advance && v3_ff && last3_ff) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end else begin
            rsp_valid_ff <= rsp_valid_ff;
         end
      end
   end

   // payload, no reset needed
   always_ff @(posedge clock) begin
      if (advance) begin
         samp1_ff  <= signed'(samp);
         last1_ff  <= req_tlast;
         sub1_ff   <= s0_sub;
         full1_ff  <= s0_full;
         first1_ff <= s0_first;

         diff2_ff  <= diff1;
         last2_ff  <= last1_ff;
         full2_ff  <= full1_ff;
         first2_ff <= first1_ff;

         last3_ff  <= last2_ff;
         full3_ff  <= full2_ff;
         first3_ff <= first2_ff;

         if (v2_ff) begin
            ws_ff <= ws_in;
         end
         if (v3_ff) begin
            best_ff <= best_in;
            bv_ff   <= bv_in;
         end
         if (v3_ff && last3_ff) begin
            rsp_sum_ff  <= rsp_sum_in;
            rsp_seen_ff <= bv_in;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_TDATA_W'(rsp_sum_ff);
   assign rsp_tuser  = rsp_seen_ff;

   // ------------------------------------------------------------------
   // assertions
   // ------------------------------------------------------------------
   a_no_window_zero_sum : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata == '0)
      else $error("result without a full window carries a nonzero sum");

   a_fill_bounded : assert property (@(posedge clock) disable iff (reset)
      fill_ff <= len_ff)
      else $error("fill count beyond window length");

   a_ready_when_out_free : assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input stalled while output register is free");

   a_last_restarts : assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tlast |=> fill_ff == '0 && wp_ff == '0)
      else $error("sequence state not cleared after last item");

endmodule

[dv/max_window_sum_tracker_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// max_window_sum_tracker_tb
// self-checking bench: signed sample sequences go in on the req stream, a
// local window-sum tracker predicts each sequence result, and every rsp item
// is compared field by field; both sides idle at random except at the end
// ----------------------------------------------------------------------------
module max_window_sum_tracker_tb
   import mwst_pkg::*;
;

   localparam int RING_DEPTH  = DEF_MAX_WINDOW;
   // let the rsp pipeline drain before touching the register
   localparam int SETTLE_CYC  = 8;
   // longest legal quiet stretch is a couple of idle bursts plus the
   // settle wait, so this is many times the slowest correct run
   localparam int IDLE_LIMIT  = 2000;
   localparam int RANDOM_ITEMS = 150;

   typedef struct packed {
      logic [MAX_SUM_W-1:0] max_sum;
      logic                 seen;
   } window_result_type;

   logic                      clock;
   logic                      reset;
   logic                      req_tvalid;
   logic                      req_tready;
   logic [SAMPLE_FIELD_W-1:0] req_tdata;   // [31:0] sample
   logic                      req_tlast;   // last_sample
   logic                      rsp_tvalid;
   logic                      rsp_tready;
   logic [RSP_TDATA_W-1:0]    rsp_tdata;   // [41:0] max_sum, rest zero
   logic                      rsp_tuser;   // [0] window_seen
   logic                      csr_wen;
   logic [LEN_CFG_W-1:0]      csr_wdata;   // [10:0] window_len

   max_window_sum_tracker dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata)
   );

   // ---------------------------------------------------------------------
   // local copy of the tracker state
   // ---------------------------------------------------------------------
   longint               hist_mem [RING_DEPTH];
   int unsigned          hist_wr;
   int unsigned          hist_count;
   longint               run_sum;
   longint               best_sum;
   logic                 best_ok;
   logic [LEN_CFG_W-1:0] win_len;

   window_result_type    expected_results [$];
   int                   mismatches;
   int                   idle_cycles;
   logic                 quiet;      // no idling on either side when set

   // length actually used: 0 acts as 1, above the ring depth saturates
   function automatic int unsigned span_of(input logic [LEN_CFG_W-1:0] len);
      if (len == 0) return 1;
      if (len > RING_DEPTH) return RING_DEPTH;
      return int'(len);
   endfunction

   function automatic void clear_sequence();
      hist_wr    = 0;
      hist_count = 0;
      run_sum    = 0;
      best_sum   = 0;
      best_ok    = 1'b0;
   endfunction

   // advance the tracker by one sample, queue a result on the last one
   function automatic void track_sample(input logic [SAMPLE_FIELD_W-1:0] raw,
                                        input logic is_last);
      int unsigned       span;
      int unsigned       old_slot;
      longint            s;
      window_result_type r;
      span = span_of(win_len);
      s = $signed(raw);
      run_sum += s;
      if (hist_count >= span) begin
         // sample leaving the window
         old_slot = (hist_wr + RING_DEPTH - span) % RING_DEPTH;
         run_sum -= hist_mem[old_slot];
      end
      hist_mem[hist_wr] = s;
      hist_wr = (hist_wr + 1) % RING_DEPTH;
      if (hist_count < span) hist_count++;
      if (hist_count >= span) begin
         if (!best_ok || run_sum > best_sum) best_sum = run_sum;
         best_ok = 1'b1;
      end
      if (is_last) begin
         r.max_sum = best_ok ? best_sum[MAX_SUM_W-1:0] : '0;
         r.seen    = best_ok;
         expected_results.push_back(r);
         clear_sequence();
      end
   endfunction

   // mostly full-range values, with a fair share of extremes and small ones
   function automatic logic [SAMPLE_FIELD_W-1:0] random_sample();
      case ($urandom_range(0, 7))
         0: return 32'h7fff_ffff;
         1: return 32'h8000_0000;
         2: return '0;
         3: return $urandom_range(0, 15) - 8;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [LEN_CFG_W-1:0] random_window_len();
      case ($urandom_range(0, 9))
         7: return '0;
         8: return LEN_CFG_W'($urandom_range(9, 40));
         9: return LEN_CFG_W'($urandom_range(0, 2047));
         default: return LEN_CFG_W'($urandom_range(1, 8));
      endcase
   endfunction

   // ---------------------------------------------------------------------
   // clock, reset, initial drive
   // ---------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // result side: random stall bursts on rsp_tready
   // ---------------------------------------------------------------------
   initial begin
      forever begin
         @(posedge clock);
         if (!quiet && $urandom_range(0, 5) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clock);
         end
         rsp_tready <= 1'b1;
      end
   end

   task automatic report_mismatch(input string what, input logic [RSP_TDATA_W-1:0] want,
                                  input logic [RSP_TDATA_W-1:0] got);
      if (mismatches < 10)
         $display("mismatch on %s: expected %h, got %h", what, want, got);
      mismatches++;
   endtask

   // compare each accepted result with the oldest expectation
   window_result_type oldest;
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_results.size() == 0) begin
            report_mismatch("unexpected result", '0, rsp_tdata);
         end else begin
            oldest = expected_results.pop_front();
            if (rsp_tdata[MAX_SUM_W-1:0] !== oldest.max_sum)
               report_mismatch("max_sum", RSP_TDATA_W'(oldest.max_sum),
                               RSP_TDATA_W'(rsp_tdata[MAX_SUM_W-1:0]));
            if (rsp_tdata[RSP_TDATA_W-1:MAX_SUM_W] !== '0)
               report_mismatch("tdata padding", '0,
                               RSP_TDATA_W'(rsp_tdata[RSP_TDATA_W-1:MAX_SUM_W]));
            if (rsp_tuser !== oldest.seen)
               report_mismatch("window_seen", RSP_TDATA_W'(oldest.seen),
                               RSP_TDATA_W'(rsp_tuser));
         end
      end
   end

   // watchdog: too long without any item moving on either side
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles + 1 >= IDLE_LIMIT) begin
            $display("status: fail");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------------
   // stimulus helpers
   // ---------------------------------------------------------------------

   // one sample item; tvalid is left high so a following item can go
   // straight out, every task that waits lowers it first
   task automatic send_sample(input logic [SAMPLE_FIELD_W-1:0] s, input logic is_last);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= s;
      req_tlast  <= is_last;
      do @(posedge clock); while (!req_tready);
      track_sample(s, is_last);
   endtask

   // stop sending, let all results arrive and the pipeline drain
   task automatic settle_block();
      req_tvalid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYC) @(posedge clock);
   endtask

   task automatic write_window_len(input logic [LEN_CFG_W-1:0] len);
      settle_block();
      csr_wen   <= 1'b1;
      csr_wdata <= len;
      @(posedge clock);
      csr_wen   <= 1'b0;
      // a write also abandons the sequence in progress
      win_len = len;
      clear_sequence();
   endtask

   task automatic send_random_run(input int count, input logic close_run);
      for (int k = 0; k < count; k++)
         send_sample(random_sample(), close_run && (k == count - 1));
   endtask

   // ---------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------

   // reset length of 1: the best window is the single largest sample
   task automatic test_reset_length_extremes();
      send_sample(32'h7fff_ffff, 1'b0);
      send_sample(32'h8000_0000, 1'b0);
      send_sample(32'h0000_0000, 1'b0);
      send_sample(32'hffff_ffff, 1'b1);
      send_sample(32'h8000_0000, 1'b1);
   endtask

   // sequence shorter than the window reports no full window, exact length does
   task automatic test_short_sequence();
      write_window_len(LEN_CFG_W'(4));
      send_sample(32'd5, 1'b0);
      send_sample(32'd6, 1'b0);
      send_sample(32'd7, 1'b1);
      send_sample(32'hffff_fff0, 1'b0);
      send_sample(32'h7fff_ffff, 1'b0);
      send_sample(32'h8000_0000, 1'b0);
      send_sample(32'd3, 1'b1);
   endtask

   // a length of zero behaves as one
   task automatic test_zero_length();
      write_window_len('0);
      send_sample(32'hffff_fffe, 1'b0);
      send_sample(32'hffff_ffff, 1'b0);
      send_sample(32'hffff_fffd, 1'b1);
   endtask

   // register write in the middle of a sequence drops what came before
   task automatic test_abandoned_sequence();
      write_window_len(LEN_CFG_W'(3));
      send_sample(32'h7fff_ffff, 1'b0);
      send_sample(32'h7fff_ffff, 1'b0);
      write_window_len(LEN_CFG_W'(2));
      send_sample(32'hffff_ff00, 1'b0);
      send_sample(32'hffff_ff01, 1'b1);
   endtask

   // saturated length over a sequence that wraps the ring: a few random
   // samples, then a full window of the most negative value
   task automatic test_full_ring();
      write_window_len('1);
      send_random_run(4, 1'b0);
      for (int k = 0; k < RING_DEPTH; k++)
         send_sample(32'h8000_0000, k == RING_DEPTH - 1);
   endtask

   // mostly well-formed sequences around the window length, some too short,
   // some cut off by a register write
   task automatic test_random_sequences();
      int          n;
      int unsigned span;
      int          seq_len;
      logic        broken;
      n = 0;
      while (n < RANDOM_ITEMS) begin
         if (n == 0 || $urandom_range(0, 3) == 0)
            write_window_len(random_window_len());
         span = span_of(win_len);
         if (span <= 40)
            seq_len = $urandom_range(span > 2 ? span - 2 : 1, span + 12);
         else
            seq_len = $urandom_range(1, 60);
         broken = ($urandom_range(0, 9) == 0);
         send_random_run(seq_len, !broken);
         n += seq_len;
         if (broken)
            write_window_len(random_window_len());
         else if ($urandom_range(0, 15) == 0)
            settle_block();   // sender waits for every pending result
      end
   endtask

   // no idling at all on either side
   task automatic test_back_to_back();
      settle_block();
      quiet = 1'b1;
      write_window_len(LEN_CFG_W'(3));
      for (int k = 0; k < 6; k++)
         send_random_run($urandom_range(1, 12), 1'b1);
      write_window_len(LEN_CFG_W'(1));
      for (int k = 0; k < 6; k++)
         send_random_run($urandom_range(1, 6), 1'b1);
   endtask

   // ---------------------------------------------------------------------
   // main sequence
   // ---------------------------------------------------------------------
   initial begin
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tlast   = 1'b0;
      rsp_tready  = 1'b0;
      csr_wen     = 1'b0;
      csr_wdata   = '0;
      quiet       = 1'b0;
      mismatches  = 0;
      idle_cycles = 0;
      for (int k = 0; k < RING_DEPTH; k++) hist_mem[k] = 0;
      win_len = LEN_CFG_W'(LEN_RESET);
      clear_sequence();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_length_extremes();
      test_short_sequence();
      test_zero_length();
      test_abandoned_sequence();
      test_full_ring();
      test_random_sequences();
      test_back_to_back();

      settle_block();
      if (mismatches == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
